### sv/lbtc_pkg.sv
// lbtc_pkg: shared widths, constants, types and the cordic arctangent table
// for the lidar beam tilt compensation block; no dependencies
package lbtc_pkg;

	localparam int RANGE_FRAC_BITS = 10;

	localparam int IDX_W      = 10;
	localparam int RNG_W      = 16;
	localparam int ANG_W      = 16;
	localparam int STEP_W     = 14;
	localparam int Q_W        = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// angles in Q3.13 radians
	localparam int TWO_PI  = 51472;
	localparam int PI      = 25736;
	localparam int HALF_PI = 12868;

	// floor(2^40 / TWO_PI), used to estimate the turn count
	localparam int RECIP_SH = 40;
	localparam longint RECIP = 64'd21361354;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_GAIN  = 652032874;
	localparam int ONE_Q14      = 16384;

	localparam int MW = 17;   // rotation coefficient width
	localparam int CW = 34;   // cordic x/y width, Q4.30
	localparam int ZW = 35;   // cordic angle width, Q5.30
	localparam int PW = 35;   // point coordinate width
	localparam int RW = 33;   // rotated coordinate width

	localparam int SAT_RAW = 32 << RANGE_FRAC_BITS;
	localparam logic [RNG_W-1:0] SAT_VAL = (SAT_RAW > 65535) ? 16'hFFFF : RNG_W'(SAT_RAW);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RANGE   = 3'd0,
		REG_MAX_RANGE   = 3'd1,
		REG_START_ANGLE = 3'd2,
		REG_ANGLE_STEP  = 3'd3,
		REG_QUAT_W      = 3'd4,
		REG_QUAT_X      = 3'd5,
		REG_QUAT_Y      = 3'd6,
		REG_QUAT_Z      = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MS_IDLE,
		MS_PROD,
		MS_NUM,
		MS_LOAD,
		MS_DIV
	} msq_state_t;

	typedef struct packed {
		logic signed [Q_W-1:0] w;
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] y;
		logic signed [Q_W-1:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [MW-1:0] m00;
		logic signed [MW-1:0] m01;
		logic signed [MW-1:0] m10;
		logic signed [MW-1:0] m11;
	} rot_mat_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             zero;
		logic             sat;
	} beam_tag_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = ZW'(843314857);
			1:  v = ZW'(497837829);
			2:  v = ZW'(263043837);
			3:  v = ZW'(133525159);
			4:  v = ZW'(67021687);
			5:  v = ZW'(33543516);
			6:  v = ZW'(16775851);
			7:  v = ZW'(8388437);
			8:  v = ZW'(4194283);
			9:  v = ZW'(2097149);
			10: v = ZW'(1048576);
			11: v = ZW'(524288);
			12: v = ZW'(262144);
			13: v = ZW'(131072);
			14: v = ZW'(65536);
			15: v = ZW'(32768);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### sv/lbtc_beam_if.sv
// lbtc_beam_if: input beam channel, valid/ready with beam payload
// depends on lbtc_pkg
interface lbtc_beam_if import lbtc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] beam_index;
	logic [RNG_W-1:0] beam_range;
	logic             scan_end;

	modport source(output valid, beam_index, beam_range, scan_end, input ready);
	modport sink(input valid, beam_index, beam_range, scan_end, output ready);
endinterface

### sv/lbtc_level_if.sv
// lbtc_level_if: output channel, valid/ready with the leveled range payload
// depends on lbtc_pkg
interface lbtc_level_if import lbtc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RNG_W-1:0] level_range;
	logic [IDX_W-1:0] out_index;
	logic             out_last;

	modport source(output valid, level_range, out_index, out_last, input ready);
	modport sink(input valid, level_range, out_index, out_last, output ready);
endinterface

### sv/lbtc_rot_matrix.sv
// lbtc_rot_matrix: builds the upper 2x2 rotation block from the quaternion
// with a shared 16-step restoring divider; depends on lbtc_pkg
module lbtc_rot_matrix import lbtc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  quat_t    quat,
	output rot_mat_t mat,
	output logic     busy
);

	localparam int NW = 48;
	localparam int QB = 16;
	localparam int DW = 33;

	msq_state_t state_q, state_d;

	logic [30:0]        sq_w_q, sq_x_q, sq_y_q, sq_z_q;
	logic signed [31:0] xy_q, wz_q;
	logic [DW-1:0]      d_q;
	logic [NW-1:0]      mag_q [4];
	logic [3:0]         sgn_q;
	logic [1:0]         k_q;
	logic [3:0]         cnt_q;
	logic [DW:0]        rem_q;
	logic [QB-1:0]      lo_q, quo_q;
	rot_mat_t           mat_q;

	logic signed [31:0] pw, px, py, pz, pxy, pwz;
	logic [31:0]        yz_sum, xz_sum;
	logic signed [32:0] dif, sum;
	logic [32:0]        dif_abs, sum_abs;
	logic [NW-1:0]      num;
	logic [DW:0]        trial;
	logic               tbit;
	logic [QB-1:0]      qn;
	logic signed [MW-1:0] qs, q_one, q_sgn;

	assign pw  = quat.w * quat.w;
	assign px  = quat.x * quat.x;
	assign py  = quat.y * quat.y;
	assign pz  = quat.z * quat.z;
	assign pxy = quat.x * quat.y;
	assign pwz = quat.w * quat.z;

	assign yz_sum  = {1'b0, sq_y_q} + {1'b0, sq_z_q};
	assign xz_sum  = {1'b0, sq_x_q} + {1'b0, sq_z_q};
	assign dif     = {xy_q[31], xy_q} - {wz_q[31], wz_q};
	assign sum     = {xy_q[31], xy_q} + {wz_q[31], wz_q};
	assign dif_abs = dif[32] ? 33'(-dif) : 33'(dif);
	assign sum_abs = sum[32] ? 33'(-sum) : 33'(sum);

	assign num   = mag_q[k_q] + NW'(d_q >> 1);
	assign trial = {rem_q[DW-1:0], lo_q[QB-1]};
	assign tbit  = (trial >= {1'b0, d_q});
	assign qn    = {quo_q[QB-2:0], tbit};
	assign qs    = $signed({1'b0, qn});
	assign q_one = MW'(ONE_Q14) - qs;
	assign q_sgn = sgn_q[k_q] ? -qs : qs;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			MS_IDLE: state_d = MS_IDLE;
			MS_PROD: state_d = MS_NUM;
			MS_NUM:  state_d = MS_LOAD;
			MS_LOAD: state_d = (d_q == '0) ? MS_IDLE : MS_DIV;
			MS_DIV: begin
				if (cnt_q == 4'(QB - 1))
					state_d = (k_q == 2'd3) ? MS_IDLE : MS_LOAD;
			end
			default: state_d = MS_IDLE;
		endcase
		if (start)
			state_d = MS_PROD;
	end

	// outputs
	always_comb begin
		busy = (state_q != MS_IDLE);
		mat  = mat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= MS_IDLE;
		else
			state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			MS_PROD: begin
				sq_w_q <= pw[30:0];
				sq_x_q <= px[30:0];
				sq_y_q <= py[30:0];
				sq_z_q <= pz[30:0];
				xy_q   <= pxy;
				wz_q   <= pwz;
			end
			MS_NUM: begin
				d_q      <= DW'(sq_w_q) + DW'(sq_x_q) + DW'(sq_y_q) + DW'(sq_z_q);
				mag_q[0] <= NW'({yz_sum, 15'b0});
				mag_q[1] <= NW'({dif_abs[31:0], 15'b0});
				mag_q[2] <= NW'({sum_abs[31:0], 15'b0});
				mag_q[3] <= NW'({xz_sum, 15'b0});
				sgn_q    <= {1'b0, sum[32], dif[32], 1'b0};
				k_q      <= '0;
			end
			MS_LOAD: begin
				rem_q <= (DW+1)'(num[NW-1:QB]);
				lo_q  <= num[QB-1:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			MS_DIV: begin
				rem_q <= tbit ? (trial - {1'b0, d_q}) : trial;
				lo_q  <= {lo_q[QB-2:0], 1'b0};
				quo_q <= qn;
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(QB - 1))
					k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

	// coefficients, identity out of reset and for a zero quaternion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '{m00: MW'(ONE_Q14), m01: '0, m10: '0, m11: MW'(ONE_Q14)};
		end else if (state_q == MS_LOAD && d_q == '0) begin
			mat_q <= '{m00: MW'(ONE_Q14), m01: '0, m10: '0, m11: MW'(ONE_Q14)};
		end else if (state_q == MS_DIV && cnt_q == 4'(QB - 1)) begin
			case (k_q)
				2'd0: mat_q.m00 <= q_one;
				2'd1: mat_q.m01 <= q_sgn;
				2'd2: mat_q.m10 <= q_sgn;
				default: mat_q.m11 <= q_one;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MS_DIV) |-> ({1'b0, rem_q} < {2'b0, d_q}))
		else $error("divider remainder not below divisor");
	a_zero_quat_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MS_LOAD && d_q == '0 && !start) |=>
		(mat_q.m00 == MW'(ONE_Q14) && mat_q.m01 == '0 && mat_q.m10 == '0 &&
		 mat_q.m11 == MW'(ONE_Q14) && !busy))
		else $error("zero quaternion did not give identity");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == MS_PROD))
		else $error("matrix update did not restart");
`endif

endmodule

### sv/laser_beam_tilt_compensation.sv
// laser_beam_tilt_compensation: top level, config registers, beam pipeline
// and output skid stage; depends on lbtc_pkg, both channel interfaces and
// lbtc_rot_matrix
//
// Takes one lidar beam per clock and gives its horizontal range after the
// vehicle tilt is rotated out. Throughput is one beam per cycle while the
// skid stage is free and no matrix update runs. The result passes 62 pipeline
// stages plus the output register, among them the 16-stage cordic and the
// 32-stage square root. A write to any quaternion register restarts the
// rotation matrix update, which runs through one shared 16-step serial
// divider (a product state and a numerator state, then a load state and the
// divider steps for each coefficient); the input is not ready during that time.
// Other register writes take effect immediately. Registers are to be written
// only while no beam is in flight.
module laser_beam_tilt_compensation import lbtc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	lbtc_beam_if.sink             beam,
	lbtc_level_if.source          level,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// stage numbering
	localparam int ST_C0  = 7;                       // first cordic step
	localparam int ST_NEG = ST_C0 + CORDIC_STEPS;    // quadrant sign fix
	localparam int ST_P1  = ST_NEG + 1;              // range times sin/cos
	localparam int ST_P2  = ST_P1 + 1;               // round to point
	localparam int ST_M1  = ST_P2 + 1;               // matrix products
	localparam int ST_M2  = ST_M1 + 1;               // sum and round
	localparam int ST_ABS = ST_M2 + 1;
	localparam int ST_SQ  = ST_ABS + 1;
	localparam int ST_SUM = ST_SQ + 1;
	localparam int ST_R0  = ST_SUM + 1;              // first root step
	localparam int NST    = ST_R0 + 31;
	localparam int PRW    = RNG_W + 1 + CW;
	localparam int MPW    = MW + PW;
	localparam int TW     = 25;

	// configuration registers
	logic [RNG_W-1:0]        min_q, max_q;
	logic signed [ANG_W-1:0] start_q;
	logic [STEP_W-1:0]       step_q;
	quat_t                   quat_q;

	rot_mat_t mat;
	logic     mx_busy;
	logic     mx_start;

	// pipeline control and side info
	logic      en;
	logic      acc;
	logic      v_s   [1:NST];
	beam_tag_t tag_s [1:NST];
	logic [RNG_W-1:0] rng_s [1:ST_NEG];

	// angle reduction
	logic [IDX_W+STEP_W-1:0] prod_s1;
	logic [TW-1:0]           t_s2, t_s3;
	logic [9:0]              qe_s3;
	logic [16:0]             r_s4;
	logic [15:0]             r_s5;
	logic signed [ZW-1:0]    z_s6;
	logic                    neg_s [6:ST_NEG-1];

	// cordic
	logic signed [CW-1:0] cx_s [ST_C0:ST_NEG-1];
	logic signed [CW-1:0] cy_s [ST_C0:ST_NEG-1];
	logic signed [ZW-1:0] cz_s [ST_C0:ST_NEG-1];

	// point, rotation and length
	logic signed [CW-1:0]  cn_s23, sn_s23;
	logic signed [PRW-1:0] pc_s24, ps_s24;
	logic signed [PW-1:0]  px_s25, py_s25;
	logic signed [MPW-1:0] ma_s26, mb_s26, mc_s26, md_s26;
	logic signed [RW-1:0]  rx_s27, ry_s27;
	logic [31:0]           ax_s28, ay_s28;
	logic [63:0]           sqx_s29, sqy_s29;
	logic [63:0]           sum_s30;
	logic [63:0]           sv_s [ST_R0:NST];
	logic [63:0]           sr_s [ST_R0:NST];

	// output register and skid stage
	logic             out_v_q, skid_v_q;
	logic [RNG_W-1:0] out_lvl_q, skid_lvl_q;
	logic [IDX_W-1:0] out_idx_q, skid_idx_q;
	logic             out_last_q, skid_last_q;

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= 16'hFFFF;
			start_q <= -16'sd25736;
			step_q  <= 14'd25;
			quat_q  <= '{w: 16'sd16384, x: '0, y: '0, z: '0};
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_RANGE:   min_q    <= cfg_data;
				REG_MAX_RANGE:   max_q    <= cfg_data;
				REG_START_ANGLE: start_q  <= cfg_data;
				REG_ANGLE_STEP:  step_q   <= cfg_data[STEP_W-1:0];
				REG_QUAT_W:      quat_q.w <= cfg_data;
				REG_QUAT_X:      quat_q.x <= cfg_data;
				REG_QUAT_Y:      quat_q.y <= cfg_data;
				REG_QUAT_Z:      quat_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	// any quaternion write rebuilds the matrix
	assign mx_start = cfg_we && (cfg_index == REG_QUAT_W || cfg_index == REG_QUAT_X ||
		cfg_index == REG_QUAT_Y || cfg_index == REG_QUAT_Z);

	lbtc_rot_matrix u_rot_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mx_start),
		.quat   (quat_q),
		.mat    (mat),
		.busy   (mx_busy)
	);

	// ---------------------------------------------------------------
	// flow control: whole pipeline advances while the skid stage is free
	// ---------------------------------------------------------------
	assign en         = !skid_v_q;
	assign beam.ready = en && !mx_busy;
	assign acc        = beam.valid && beam.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= acc;
			for (int k = 2; k <= NST; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	// side info rides along with its beam
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[1].idx  <= beam.beam_index;
			tag_s[1].last <= beam.scan_end;
			// near minimum wins over near maximum
			tag_s[1].zero <= ({1'b0, beam.beam_range} <= ({1'b0, min_q} + 17'd1));
			tag_s[1].sat  <= ($signed({2'b0, beam.beam_range}) >=
				($signed({2'b0, max_q}) - 18'sd1));
			rng_s[1]      <= beam.beam_range;
			for (int k = 2; k <= NST; k++)
				tag_s[k] <= tag_s[k-1];
			for (int k = 2; k <= ST_NEG; k++)
				rng_s[k] <= rng_s[k-1];
		end
	end

	// ---------------------------------------------------------------
	// beam angle, reduced into [-pi/2, pi/2] with a sign flag
	// ---------------------------------------------------------------
	logic signed [TW:0]    t_full;
	logic [49:0]           recip_prod;
	logic [25:0]           turn_sub;
	logic [25:0]           turn_diff;
	logic signed [17:0]    a0, a1, a2;
	logic                  fold;

	// add one turn up front so the angle is never negative
	assign t_full     = $signed({{(TW+1-ANG_W){start_q[ANG_W-1]}}, start_q}) +
		(TW+1)'(TWO_PI) + $signed({2'b0, prod_s1});
	assign recip_prod = t_s2 * TW'(RECIP);
	assign turn_sub   = qe_s3 * 16'(TWO_PI);
	assign turn_diff  = {1'b0, t_s3} - turn_sub;

	always_comb begin
		a0   = $signed({2'b0, r_s5});
		a1   = (r_s5 > 16'(PI)) ? (a0 - 18'sd51472) : a0;
		a2   = a1;
		fold = 1'b0;
		if (a1 > 18'sd12868) begin
			a2   = a1 - 18'sd25736;
			fold = 1'b1;
		end else if (a1 < -18'sd12868) begin
			a2   = a1 + 18'sd25736;
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= beam.beam_index * step_q;
			t_s2     <= t_full[TW-1:0];
			// turn count estimate, low by at most one
			qe_s3    <= recip_prod[49:RECIP_SH];
			t_s3     <= t_s2;
			r_s4     <= turn_diff[16:0];
			r_s5     <= (r_s4 >= 17'(TWO_PI)) ? 16'(r_s4 - 17'(TWO_PI)) : r_s4[15:0];
			z_s6     <= ZW'(a2) <<< 17;
			neg_s[6] <= fold;
			for (int k = ST_C0; k < ST_NEG; k++)
				neg_s[k] <= neg_s[k-1];
		end
	end

	// ---------------------------------------------------------------
	// cordic, one rotation step per stage
	// ---------------------------------------------------------------
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam int K = ST_C0 + i;
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi;
		if (i == 0) begin : g_first
			assign xi = CW'(CORDIC_GAIN);
			assign yi = '0;
			assign zi = z_s6;
		end else begin : g_next
			assign xi = cx_s[K-1];
			assign yi = cy_s[K-1];
			assign zi = cz_s[K-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					cx_s[K] <= xi - (yi >>> i);
					cy_s[K] <= yi + (xi >>> i);
					cz_s[K] <= zi - atan_q30(i);
				end else begin
					cx_s[K] <= xi + (yi >>> i);
					cy_s[K] <= yi - (xi >>> i);
					cz_s[K] <= zi + atan_q30(i);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// point in the sensor plane, rotation, squared length
	// ---------------------------------------------------------------
	logic signed [PRW-1:0]   pc_rnd, ps_rnd;
	logic signed [MPW:0]     rx_sum, ry_sum;
	logic signed [RW-1:0]    rx_neg, ry_neg;

	assign pc_rnd = pc_s24 + PRW'(32768);
	assign ps_rnd = ps_s24 + PRW'(32768);
	assign rx_sum = (MPW+1)'(ma_s26) + (MPW+1)'(mb_s26) + (MPW+1)'(8192);
	assign ry_sum = (MPW+1)'(mc_s26) + (MPW+1)'(md_s26) + (MPW+1)'(8192);
	assign rx_neg = -rx_s27;
	assign ry_neg = -ry_s27;

	always_ff @(posedge clk) begin
		if (en) begin
			// undo the half-turn fold
			cn_s23  <= neg_s[ST_NEG-1] ? -cx_s[ST_NEG-1] : cx_s[ST_NEG-1];
			sn_s23  <= neg_s[ST_NEG-1] ? -cy_s[ST_NEG-1] : cy_s[ST_NEG-1];
			pc_s24  <= $signed({1'b0, rng_s[ST_NEG]}) * cn_s23;
			ps_s24  <= $signed({1'b0, rng_s[ST_NEG]}) * sn_s23;
			px_s25  <= pc_rnd[PRW-1:16];
			py_s25  <= ps_rnd[PRW-1:16];
			ma_s26  <= mat.m00 * px_s25;
			mb_s26  <= mat.m01 * py_s25;
			mc_s26  <= mat.m10 * px_s25;
			md_s26  <= mat.m11 * py_s25;
			rx_s27  <= rx_sum[14+RW-1:14];
			ry_s27  <= ry_sum[14+RW-1:14];
			ax_s28  <= rx_s27[RW-1] ? rx_neg[31:0] : rx_s27[31:0];
			ay_s28  <= ry_s27[RW-1] ? ry_neg[31:0] : ry_s27[31:0];
			sqx_s29 <= ax_s28 * ax_s28;
			sqy_s29 <= ay_s28 * ay_s28;
			sum_s30 <= sqx_s29 + sqy_s29;
		end
	end

	// ---------------------------------------------------------------
	// integer square root, one result bit per stage
	// ---------------------------------------------------------------
	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		localparam int K = ST_R0 + k;
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] vi, ri, trial;
		if (k == 0) begin : g_first
			assign vi = sum_s30;
			assign ri = '0;
		end else begin : g_next
			assign vi = sv_s[K-1];
			assign ri = sr_s[K-1];
		end
		assign trial = ri + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (vi >= trial) begin
					sv_s[K] <= vi - trial;
					sr_s[K] <= (ri >> 1) + BIT;
				end else begin
					sv_s[K] <= vi;
					sr_s[K] <= ri >> 1;
				end
			end
		end
	end

	// round to Q6.10, saturate, apply the near-limit overrides
	logic [63:0]      root_rnd;
	logic [RNG_W-1:0] lvl_clip, lvl;

	assign root_rnd = sr_s[NST] + 64'd8192;
	assign lvl_clip = (|root_rnd[63:14+RNG_W]) ? '1 : root_rnd[14+RNG_W-1:14];
	assign lvl      = tag_s[NST].zero ? '0 : (tag_s[NST].sat ? SAT_VAL : lvl_clip);

	// ---------------------------------------------------------------
	// output register with skid stage
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || level.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s[NST];
			end
		end else if (v_s[NST] && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || level.ready) begin
			if (skid_v_q) begin
				out_lvl_q  <= skid_lvl_q;
				out_idx_q  <= skid_idx_q;
				out_last_q <= skid_last_q;
			end else begin
				out_lvl_q  <= lvl;
				out_idx_q  <= tag_s[NST].idx;
				out_last_q <= tag_s[NST].last;
			end
		end else if (v_s[NST] && en) begin
			skid_lvl_q  <= lvl;
			skid_idx_q  <= tag_s[NST].idx;
			skid_last_q <= tag_s[NST].last;
		end
	end

	assign level.valid       = out_v_q;
	assign level.level_range = out_lvl_q;
	assign level.out_index   = out_idx_q;
	assign level.out_last    = out_last_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds a beam while output is empty");
	a_no_beam_after_quat: assert property (@(posedge clk) disable iff (!arst_n)
		mx_start |=> !beam.ready)
		else $error("beam transfer allowed during matrix update");
	a_last_stage_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[NST] && en) |=> (out_v_q || skid_v_q))
		else $error("beam leaving the pipeline was dropped");
`endif

endmodule

### verif/tb_laser_beam_tilt_compensation.sv
// tb_laser_beam_tilt_compensation: self-checking bench for the lidar beam tilt
// compensation block; predicts each leveled range from the beam and the registers
// depends on lbtc_pkg, lbtc_beam_if, lbtc_level_if and the block itself
module tb_laser_beam_tilt_compensation;
	import lbtc_pkg::*;

	typedef struct {
		logic [RNG_W-1:0] lvl;
		logic [IDX_W-1:0] idx;
		logic             last;
	} level_item_t;

	// keeps the register copy, computes the leveled range and holds the
	// results still owed by the block
	class level_scoreboard;
		logic [15:0]       min_rng, max_rng, ang0, qw, qx, qy, qz;
		logic [STEP_W-1:0] ang_step;
		level_item_t       owed[$];
		int                errors;

		static const longint ATAN[16] = '{843314857, 497837829, 263043837,
			133525159, 67021687, 33543516, 16775851, 8388437, 4194283,
			2097149, 1048576, 524288, 262144, 131072, 65536, 32768};

		function new();
			errors = 0;
			set_reg(REG_MIN_RANGE, 16'd0);
			set_reg(REG_MAX_RANGE, 16'hFFFF);
			set_reg(REG_START_ANGLE, 16'(-25736));
			set_reg(REG_ANGLE_STEP, 16'd25);
			set_reg(REG_QUAT_W, 16'd16384);
			set_reg(REG_QUAT_X, 16'd0);
			set_reg(REG_QUAT_Y, 16'd0);
			set_reg(REG_QUAT_Z, 16'd0);
		endfunction

		function void set_reg(cfg_reg_t r, logic [15:0] v);
			case (r)
				REG_MIN_RANGE:   min_rng = v;
				REG_MAX_RANGE:   max_rng = v;
				REG_START_ANGLE: ang0 = v;
				REG_ANGLE_STEP:  ang_step = v[STEP_W-1:0];
				REG_QUAT_W:      qw = v;
				REG_QUAT_X:      qx = v;
				REG_QUAT_Y:      qy = v;
				REG_QUAT_Z:      qz = v;
				default: ;
			endcase
		endfunction

		function longint rshift_round(longint v, int n);
			return (v + (longint'(1) <<< (n - 1))) >>> n;
		endfunction

		function longint quot_round(longint num, longint den);
			longint mag;
			longint q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -q : q;
		endfunction

		function longint unsigned floor_sqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic [RNG_W-1:0] level_of(logic [IDX_W-1:0] idx, logic [RNG_W-1:0] rng);
			longint r, x, y, z, dx, dy, s, c, px, py, rx, ry;
			longint w, qxs, qys, qzs, d, m00, m01, m10, m11;
			longint unsigned ax, ay, root, res;
			bit flip;
			if (longint'(rng) <= longint'(min_rng) + 1) return '0;
			if (longint'(rng) >= longint'(max_rng) - 1) return SAT_VAL;
			// angle reduction into (-pi, pi], then fold into +-pi/2
			r = longint'($signed(ang0)) + longint'(idx) * longint'(ang_step);
			r = r % 51472;
			if (r < 0) r += 51472;
			if (r > 25736) r -= 51472;
			flip = 0;
			if (r > 12868) begin
				r -= 25736;
				flip = 1;
			end else if (r < -12868) begin
				r += 25736;
				flip = 1;
			end
			x = 652032874;
			y = 0;
			z = r * 131072;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN[i];
				end else begin
					x += dx; y -= dy; z += ATAN[i];
				end
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
			px = rshift_round(longint'(rng) * c, 16);
			py = rshift_round(longint'(rng) * s, 16);
			w = $signed(qw); qxs = $signed(qx); qys = $signed(qy); qzs = $signed(qz);
			d = w * w + qxs * qxs + qys * qys + qzs * qzs;
			m00 = 16384; m01 = 0; m10 = 0; m11 = 16384;
			if (d != 0) begin
				m00 = 16384 - quot_round(2 * (qys * qys + qzs * qzs) * 16384, d);
				m01 = quot_round(2 * (qxs * qys - w * qzs) * 16384, d);
				m10 = quot_round(2 * (qxs * qys + w * qzs) * 16384, d);
				m11 = 16384 - quot_round(2 * (qxs * qxs + qzs * qzs) * 16384, d);
			end
			rx = rshift_round(m00 * px + m01 * py, 14);
			ry = rshift_round(m10 * px + m11 * py, 14);
			ax = (rx < 0) ? -rx : rx;
			ay = (ry < 0) ? -ry : ry;
			root = floor_sqrt(ax * ax + ay * ay);
			res = (root + 8192) >> 14;
			return (res > 65535) ? 16'hFFFF : res[15:0];
		endfunction

		function void note_beam(logic [IDX_W-1:0] idx, logic [RNG_W-1:0] rng, logic last);
			level_item_t e;
			e.lvl = level_of(idx, rng);
			e.idx = idx;
			e.last = last;
			owed.push_back(e);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_level(logic [RNG_W-1:0] lvl, logic [IDX_W-1:0] idx, logic last);
			level_item_t e;
			if (owed.size() == 0) begin
				report("unexpected result, index", idx, -1);
			end else begin
				e = owed.pop_front();
				if (lvl !== e.lvl) report("level_range", lvl, e.lvl);
				if (idx !== e.idx) report("out_index", idx, e.idx);
				if (last !== e.last) report("out_last", last, e.last);
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lbtc_beam_if  beam_ch();
	lbtc_level_if level_ch();

	laser_beam_tilt_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.beam(beam_ch),
		.level(level_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	level_scoreboard sb;
	bit              no_idle;     // phase runs with both sides at full rate
	bit              hold_req;    // asks the receiver for one long hold-off

	always #5 clk = ~clk;

	// overall limit, far above the slowest legal run
	initial begin
		#20000000;
		$display("tb_laser_beam_tilt_compensation: FAIL");
		$finish;
	end

	// gap length: mostly short, now and then long
	function automatic int pick_gap();
		if (no_idle) return 0;
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
		return $urandom_range(8, 40);
	endfunction

	// receiver: checks each result transfer, then picks its next ready
	initial begin
		int stall;
		stall = 0;
		level_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (level_ch.valid && level_ch.ready)
				sb.check_level(level_ch.level_range, level_ch.out_index, level_ch.out_last);
			if (hold_req) begin
				// long hold-off so the pipeline fills and stalls the input
				hold_req = 0;
				stall = 400;
			end else if (stall == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				level_ch.ready <= 1'b0;
				stall--;
			end else begin
				level_ch.ready <= 1'b1;
			end
		end
	end

	// offer one beam and hold it until the transfer; valid stays high if no gap follows
	task send_beam(logic [IDX_W-1:0] idx, logic [RNG_W-1:0] rng, logic last);
		int gap;
		beam_ch.beam_index <= idx;
		beam_ch.beam_range <= rng;
		beam_ch.scan_end <= last;
		beam_ch.valid <= 1'b1;
		do @(posedge clk); while (!beam_ch.ready);
		sb.note_beam(idx, rng, last);
		gap = pick_gap();
		if (gap > 0) begin
			beam_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// let everything in flight come out, then idle past the pipeline depth
	task drain();
		beam_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// write all eight registers back to back; write enable stays high throughout
	task load_regs(logic [15:0] mn, logic [15:0] mx, logic [15:0] a0, logic [15:0] st,
			logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		logic [15:0] v[8];
		v = '{mn, mx, a0, st, w, x, y, z};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= v[i];
			@(posedge clk);
			sb.set_reg(cfg_reg_t'(i), v[i]);
		end
		cfg_we <= 1'b0;
		// the matrix update holds off the input; transfers wait on ready anyway
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 16'd16384;
			1: return 16'(-16384);
			2: return 16'd0;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// random beam: full-range values plus ranges hugging both thresholds
	task random_beams(int n);
		logic [RNG_W-1:0] rng;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			if (k < 6) rng = $urandom_range(0, 65535);
			else if (k < 8) rng = 16'(int'(sb.min_rng) + $urandom_range(0, 3));
			else rng = 16'(int'(sb.max_rng) - $urandom_range(0, 3));
			send_beam($urandom_range(0, 1023), rng, $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		logic [15:0] mn;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		beam_ch.valid = 1'b0;
		beam_ch.beam_index = '0;
		beam_ch.beam_range = '0;
		beam_ch.scan_end = 1'b0;
		no_idle = 0;
		hold_req = 0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, index and range extremes
		send_beam(10'd0, 16'd0, 1'b0);
		send_beam(10'd1023, 16'd1, 1'b1);
		send_beam(10'd0, 16'd2, 1'b0);
		send_beam(10'd512, 16'hFFFF, 1'b0);
		send_beam(10'd1023, 16'hFFFE, 1'b1);
		send_beam(10'd1023, 16'hFFFD, 1'b0);
		send_beam(10'd300, 16'd5000, 1'b0);
		drain();
		// near-min and near-max edges with tight limits, tilted frame
		load_regs(16'd1000, 16'd20000, 16'd0, 16'd8192, 16'd15000, 16'd3000,
			16'd4000, 16'd2000);
		send_beam(10'd1, 16'd1001, 1'b0);
		send_beam(10'd2, 16'd1002, 1'b0);
		send_beam(10'd3, 16'd19999, 1'b0);
		send_beam(10'd4, 16'd19998, 1'b1);
		send_beam(10'd1023, 16'd10000, 1'b0);
		drain();
		// zero quaternion falls back to identity; start angle at +pi
		load_regs(16'd0, 16'hFFFF, 16'd25736, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_beam(10'd0, 16'd40000, 1'b0);
		send_beam(10'd1023, 16'd65532, 1'b1);
		drain();
		// a pure-axis quaternion, then limits that clip everything
		load_regs(16'd0, 16'hFFFF, 16'(-25736), 16'd8192, 16'd0, 16'd16384,
			16'd0, 16'd0);
		send_beam(10'd1023, 16'd30000, 1'b0);
		send_beam(10'd777, 16'd65533, 1'b0);
		drain();
		load_regs(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'(-16384), 16'(-16384),
			16'd16384, 16'(-16384));
		send_beam(10'd5, 16'hFFFF, 1'b1);
		send_beam(10'd6, 16'd100, 1'b0);
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 7; ph++) begin
			mn = (ph == 6) ? 16'd0 : $urandom_range(0, 3000);
			load_regs(mn, (ph == 5) ? 16'hFFFF : 16'($urandom_range(40000, 65535)),
				(ph == 0) ? 16'd25736 : (ph == 1) ? 16'(-25736)
					: 16'($signed($urandom_range(0, 51472)) - 25736),
				(ph == 2) ? 16'd8192 : (ph == 3) ? 16'd0 : 16'($urandom_range(0, 8192)),
				rand_q(), rand_q(), rand_q(), rand_q());
			// the hold-off phase sends back to back so the pipeline fills up
			no_idle = (ph == 4) || (ph == 1);
			if (ph == 1) hold_req = 1;
			random_beams(70);
			drain();
		end
		no_idle = 0;

		if (sb.errors == 0) begin
			$display("tb_laser_beam_tilt_compensation: PASS");
		end else begin
			$display("tb_laser_beam_tilt_compensation: FAIL");
		end
		$finish;
	end

endmodule
